>>> rtl/rafl_pkg.sv
// ----------------------------------------------------------------------------
// rafl_pkg: range-add first/last match table, shared definitions
// Sizes, function codes and the word that travels along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rafl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 48;

  localparam int FIELD_IDX_W = 11;
  localparam int OPERAND_W   = 48;
  localparam int SPAN_W      = 11;
  localparam int FUNC_W      = 2;
  localparam int S_DATA_W    = 72;
  localparam int M_DATA_W    = 16;

  localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (IDX_W > FIELD_IDX_W) ? IDX_W : FIELD_IDX_W;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic                   valid;
    logic [FUNC_W-1:0]      func;
    logic [FIELD_IDX_W-1:0] first;
    logic [FIELD_IDX_W-1:0] last;
    logic [VALUE_BITS-1:0]  key;
    logic                   found;
    logic [IDX_W-1:0]       lo;
    logic [IDX_W-1:0]       hi;
  } rafl_word_t;

endpackage

`default_nettype wire

>>> rtl/rafl_cell.sv
// ----------------------------------------------------------------------------
// rafl_cell: one table entry of the chain
// Holds one entry value, applies the passing word to it and hands the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module rafl_cell (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              advance,
  input  wire  [rafl_pkg::CMP_W-1:0]       cell_index,
  input  wire  [rafl_pkg::CMP_W-1:0]       used_count,
  input  wire  rafl_pkg::rafl_word_t       word_in,
  output rafl_pkg::rafl_word_t             word_out
);
  import rafl_pkg::*;

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] value_next;
  logic [VALUE_BITS:0]   sum;
  logic                  in_use;
  logic [CMP_W-1:0]      first_c;
  logic [CMP_W-1:0]      last_c;
  rafl_word_t            word_next;

  always_comb begin
    word_next  = word_in;
    value_next = value;
    in_use     = word_in.valid && (cell_index <= used_count);
    first_c    = CMP_W'(word_in.first);
    last_c     = CMP_W'(word_in.last);
    sum        = {1'b0, value} + {1'b0, word_in.key};
    case (word_in.func)
      FUNC_LOAD: begin
        if (in_use && first_c == cell_index) value_next = word_in.key;
      end
      FUNC_ADD: begin
        if (in_use && first_c <= cell_index && cell_index <= last_c) begin
          value_next = sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
        end
      end
      FUNC_QUERY: begin
        if (in_use && value == word_in.key) begin
          if (!word_in.found) word_next.lo = IDX_W'(cell_index);
          word_next.hi    = IDX_W'(cell_index);
          word_next.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else if (advance) begin
      value    <= value_next;
      word_out <= word_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rafl_out.sv
// ----------------------------------------------------------------------------
// rafl_out: result register at the end of the chain
// Turns a finished query word into a span and holds it until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rafl_out (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  rafl_pkg::rafl_word_t       word_in,
  input  wire                              m_ready,
  output logic                             m_valid,
  output logic [rafl_pkg::SPAN_W-1:0]      span,
  output logic                             advance
);
  import rafl_pkg::*;

  logic is_result;

  assign is_result = word_in.valid && word_in.func == FUNC_QUERY;
  assign advance   = !m_valid || m_ready || !is_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance && is_result) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
    if (advance && is_result) begin
      span <= word_in.found ? SPAN_W'(word_in.hi - word_in.lo) : {SPAN_W{1'b1}};
    end
  end

endmodule

`default_nettype wire

>>> rtl/range_add_first_last_match_table_top.sv
// ----------------------------------------------------------------------------
// range_add_first_last_match_table_top: range-add / first-last match table
// An accepted word passes every cell register of the chain, then the result register.
// Throughput: one word per cycle while not stalled; each word moves one cell of the chain a cycle.
// Load and range-add words give no result; the chain stalls only on a held result.
// Reset clears word valid flags and sets the entry count to 1024.
// Entry values are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module range_add_first_last_match_table_top (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // first_index[10:0], last_index[21:11], operand_value[69:22], zero pad
  input  wire  [rafl_pkg::S_DATA_W-1:0]        s_tdata,
  // func[1:0]
  input  wire  [rafl_pkg::FUNC_W-1:0]          s_tuser,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // span[10:0], zero pad
  output logic [rafl_pkg::M_DATA_W-1:0]        m_tdata,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [rafl_pkg::FIELD_IDX_W-1:0]     cfg_data
);
  import rafl_pkg::*;

  logic [FIELD_IDX_W-1:0] entries_in_use;
  logic [CMP_W-1:0]       used_count;
  logic                   advance;
  logic [SPAN_W-1:0]      span;
  rafl_word_t             chain [TABLE_DEPTH+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= FIELD_IDX_W'(1024);
    end else if (cfg_valid) begin
      entries_in_use <= cfg_data;
    end
  end

  assign used_count = (CMP_W'(entries_in_use) > CMP_W'(TABLE_DEPTH)) ?
                      CMP_W'(TABLE_DEPTH) : CMP_W'(entries_in_use);

  assign s_tready = advance && !rst;

  always_comb begin
    chain[0].valid = s_tvalid;
    chain[0].func  = s_tuser;
    chain[0].first = s_tdata[FIELD_IDX_W-1:0];
    chain[0].last  = s_tdata[2*FIELD_IDX_W-1:FIELD_IDX_W];
    chain[0].key   = VALUE_BITS'(s_tdata[2*FIELD_IDX_W+OPERAND_W-1:2*FIELD_IDX_W]);
    chain[0].found = 1'b0;
    chain[0].lo    = '0;
    chain[0].hi    = '0;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    rafl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (CMP_W'(k + 1)),
      .used_count (used_count),
      .word_in    (chain[k]),
      .word_out   (chain[k+1])
    );
  end

  rafl_out u_out (
    .clk     (clk),
    .rst     (rst),
    .word_in (chain[TABLE_DEPTH]),
    .m_ready (m_tready),
    .m_valid (m_tvalid),
    .span    (span),
    .advance (advance)
  );

  assign m_tdata = M_DATA_W'(span);

`ifndef SYNTH
  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("chain stalled without a held result");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word straight after reset");

  a_span_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && span != {SPAN_W{1'b1}} && TABLE_DEPTH <= 1024 |->
      CMP_W'(span) < used_count)
    else $error("span outside entries in use");
`endif

endmodule

`default_nettype wire

>>> bench/match_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_span_checker: scoreboard for the range-add first/last match table
// Watches the input, result and count channels. Keeps its own copy of the
// table and the entry count, works out the span of every accepted query word
// and compares each result word with the oldest span still owed.
// ----------------------------------------------------------------------------
module match_span_checker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  input  wire                               s_tready,
  // first_index[10:0], last_index[21:11], operand_value[69:22], zero pad
  input  wire  [rafl_pkg::S_DATA_W-1:0]     s_tdata,
  // func[1:0]
  input  wire  [rafl_pkg::FUNC_W-1:0]       s_tuser,
  input  wire                               m_tvalid,
  input  wire                               m_tready,
  // span[10:0], zero pad
  input  wire  [rafl_pkg::M_DATA_W-1:0]     m_tdata,
  input  wire                               cfg_valid,
  input  wire                               cfg_ready,
  input  wire  [rafl_pkg::FIELD_IDX_W-1:0]  cfg_data,
  output int                                fault_count,
  output int                                spans_owed,
  output int                                spans_checked,
  output int                                spans_found
);
  import rafl_pkg::*;

  logic [VALUE_BITS-1:0]  entry_copy [1:TABLE_DEPTH];
  logic [FIELD_IDX_W-1:0] count_copy;
  logic [SPAN_W-1:0]      span_due [$];

  task automatic log_fault(input string what, input logic [SPAN_W-1:0] want,
                           input logic [SPAN_W-1:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t %s: expected %0d, got %0d", $time, what, $signed(want), $signed(got));
  endtask

  task automatic apply_word(input logic [FUNC_W-1:0] f, input logic [FIELD_IDX_W-1:0] fi,
                            input logic [FIELD_IDX_W-1:0] la,
                            input logic [VALUE_BITS-1:0] v);
    int n, a, b, lo, hi;
    bit hit;
    logic [VALUE_BITS:0] sum;
    n = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy);
    case (f)
      FUNC_LOAD: begin
        if (fi >= 1 && fi <= n) entry_copy[fi] = v;
      end
      FUNC_ADD: begin
        a = (fi < 1) ? 1 : int'(fi);
        b = (la > n) ? n : int'(la);
        for (int i = a; i <= b; i++) begin
          sum = {1'b0, entry_copy[i]} + {1'b0, v};
          entry_copy[i] = sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
        end
      end
      FUNC_QUERY: begin
        hit = 1'b0;
        lo = 0;
        hi = 0;
        for (int i = 1; i <= n; i++) begin
          if (entry_copy[i] == v) begin
            if (!hit) lo = i;
            hi = i;
            hit = 1'b1;
          end
        end
        if (hit) begin
          span_due.insert(span_due.size(), SPAN_W'(hi - lo));
          spans_found++;
        end else begin
          span_due.insert(span_due.size(), {SPAN_W{1'b1}});
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_copy = FIELD_IDX_W'(TABLE_DEPTH);
      span_due.delete();
      fault_count = 0;
      spans_checked = 0;
      spans_found = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (span_due.size() == 0) begin
          log_fault("span word with no query owed", {SPAN_W{1'bx}}, m_tdata[SPAN_W-1:0]);
        end else begin
          spans_checked++;
          if (m_tdata[SPAN_W-1:0] !== span_due[0])
            log_fault("span mismatch", span_due[0], m_tdata[SPAN_W-1:0]);
          void'(span_due.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) count_copy = cfg_data;
      if (s_tvalid && s_tready)
        apply_word(s_tuser, s_tdata[FIELD_IDX_W-1:0],
                   s_tdata[2*FIELD_IDX_W-1:FIELD_IDX_W],
                   s_tdata[2*FIELD_IDX_W +: VALUE_BITS]);
    end
    spans_owed = span_due.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the range-add first/last match table
// Directed words for the empty and single-entry tables, then random words over
// a series of entry counts, each table filled before it is searched. Idling on
// both sides in turn, plus one long output hold that backs up the chain.
// ----------------------------------------------------------------------------
module tb_top;
  import rafl_pkg::*;

  localparam int LATENCY     = TABLE_DEPTH + 1;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [FUNC_W-1:0]     FUNC_SPARE = 2'd3;
  localparam logic [VALUE_BITS-1:0] VAL_MAX    = {VALUE_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] WIDE_KEY   = 48'h5A5A_C3C3_A5A5;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata = '0;
  logic [FUNC_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [FIELD_IDX_W-1:0] cfg_data = '0;

  int fault_count, spans_owed, spans_checked, spans_found;
  int send_gap_pct = 16;
  int recv_gap_pct = 51;
  int cycles = 0;
  int words_sent = 0;
  int count_writes = 0;
  int unsigned live_count = TABLE_DEPTH;
  bit hold_req = 1'b0;
  bit hold_off = 1'b0;
  bit filled [1:TABLE_DEPTH];
  logic [VALUE_BITS-1:0] recent_val = '0;

  range_add_first_last_match_table_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  match_span_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fault_count(fault_count), .spans_owed(spans_owed),
    .spans_checked(spans_checked), .spans_found(spans_found)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= !hold_off && ($urandom_range(99) >= recv_gap_pct);

  // long output hold so the chain fills and backs up the input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return VALUE_BITS'($urandom_range(9));
    if (r < 75) return VAL_MAX - VALUE_BITS'($urandom_range(3));
    return VALUE_BITS'({$urandom, $urandom});
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [FIELD_IDX_W-1:0] fi,
                           input logic [FIELD_IDX_W-1:0] la,
                           input logic [VALUE_BITS-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {{(S_DATA_W - 2*FIELD_IDX_W - VALUE_BITS){1'b0}}, v, la, fi};
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (f == FUNC_LOAD) begin
      recent_val = v;
      if (fi >= 1 && fi <= live_count && fi <= TABLE_DEPTH) filled[fi] = 1'b1;
    end
  endtask

  task automatic write_count(input int unsigned n);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= FIELD_IDX_W'(n);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    live_count = n;
    count_writes++;
  endtask

  // load every entry now in use that has never held a value
  task automatic fill_in_use();
    int unsigned top_idx;
    top_idx = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : live_count;
    for (int i = 1; i <= top_idx; i++)
      if (!filled[i]) send_word(FUNC_LOAD, FIELD_IDX_W'(i), FIELD_IDX_W'($urandom), pick_value());
  endtask

  // idle point: every span in, then let loads and adds clear the chain
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (spans_owed == 0);
    repeat (LATENCY + 16) @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned nn, pick, r;
    logic [FUNC_W-1:0]      f;
    logic [FIELD_IDX_W-1:0] fi, la;
    logic [VALUE_BITS-1:0]  v;
    nn = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : live_count;
    pick = $urandom_range(99);
    r = $urandom_range(99);
    fi = FIELD_IDX_W'($urandom_range(nn + 1));
    la = FIELD_IDX_W'($urandom_range(nn + 1));
    if ($urandom_range(9) == 0) fi = FIELD_IDX_W'($urandom);
    if ($urandom_range(9) == 0) la = FIELD_IDX_W'($urandom);
    if (pick < 35) begin
      f = FUNC_LOAD;
      if (nn > 0 && $urandom_range(9) != 0) fi = FIELD_IDX_W'($urandom_range(nn, 1));
      v = pick_value();
    end else if (pick < 60) begin
      f = FUNC_ADD;
      if ($urandom_range(3) != 0 && fi > la) {fi, la} = {la, fi};
      if (r < 60) v = VALUE_BITS'($urandom_range(1));
      else if (r < 85) v = VALUE_BITS'($urandom_range(15));
      else if (r < 93) v = VALUE_BITS'({$urandom, $urandom});
      else v = VAL_MAX - VALUE_BITS'($urandom_range(3));
    end else if (pick < 95) begin
      f = FUNC_QUERY;
      if (r < 45) v = VALUE_BITS'($urandom_range(15));
      else if (r < 65) v = VAL_MAX - VALUE_BITS'($urandom_range(3));
      else if (r < 85) v = recent_val;
      else v = VALUE_BITS'({$urandom, $urandom});
    end else begin
      f = FUNC_SPARE;
      v = VALUE_BITS'({$urandom, $urandom});
    end
    send_word(f, fi, la, v);
  endtask

  initial begin : stimulus
    int unsigned n_cfg, n_words;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // empty table
    write_count(0);
    send_word(FUNC_LOAD, 1, 0, 5);
    send_word(FUNC_ADD, 0, 2047, 1);
    send_word(FUNC_QUERY, 0, 0, 0);
    send_word(FUNC_SPARE, 3, 9, VAL_MAX);
    send_word(FUNC_QUERY, 0, 0, 5);
    settle();

    // single entry: saturation, ignored loads, clipped and empty ranges
    write_count(1);
    send_word(FUNC_LOAD, 1, 0, VAL_MAX);
    send_word(FUNC_ADD, 0, 2047, 1);
    send_word(FUNC_QUERY, 0, 0, VAL_MAX);
    send_word(FUNC_LOAD, 0, 0, 7);
    send_word(FUNC_LOAD, 2, 0, 9);
    send_word(FUNC_QUERY, 2047, 2047, 9);
    send_word(FUNC_QUERY, 0, 0, 7);
    send_word(FUNC_LOAD, 1, 0, VAL_MAX - 2);
    send_word(FUNC_ADD, 1, 1, 5);
    send_word(FUNC_QUERY, 0, 0, VAL_MAX);
    send_word(FUNC_LOAD, 1, 0, 0);
    send_word(FUNC_ADD, 1, 0, 3);
    send_word(FUNC_QUERY, 0, 0, 0);
    send_word(FUNC_ADD, 1, 1, VAL_MAX);
    send_word(FUNC_QUERY, 0, 0, VAL_MAX);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin n_cfg = 2;    n_words = 90;  end
        1: begin n_cfg = 37;   n_words = 90;  end
        2: begin n_cfg = 5;    n_words = 70;  end
        3: begin n_cfg = 150;  n_words = 80;  end
        4: begin n_cfg = 2047; n_words = 120; end
        5: begin n_cfg = 1024; n_words = 40;  end
        6: begin n_cfg = 300;  n_words = 20;  end
        default: begin n_cfg = 1; n_words = 10; end
      endcase
      if (p == 2) begin
        send_gap_pct = 51;
        recv_gap_pct = 16;
      end
      if (p == 4) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      write_count(n_cfg);
      fill_in_use();
      if (p == 4) begin
        // matches at both ends of the full table; two queries run ahead of a
        // pause so the held output stalls the chain as soon as words resume
        send_word(FUNC_LOAD, 1, 0, WIDE_KEY);
        send_word(FUNC_LOAD, 1024, 0, WIDE_KEY);
        send_word(FUNC_QUERY, 0, 0, WIDE_KEY);
        send_word(FUNC_QUERY, 0, 0, VAL_MAX);
        hold_req = 1'b1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (LATENCY) @(negedge clk);
      end
      repeat (n_words) send_random();
      settle();
    end

    $display("Sent %0d words over %0d entry counts (0, 1 to 2047), long output hold once.",
             words_sent, count_writes);
    $display("Checked %0d spans, %0d with a match; %0d faults.",
             spans_checked, spans_found, fault_count);
    if (fault_count == 0 && spans_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
